@@ rtl/pprht_pkg.sv @@
package pprht_pkg;

  localparam int S_DATA_W   = 96;
  localparam int M_DATA_W   = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 16;
  localparam int RAD_W   = 31;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 65;
  localparam int DOT_W  = 36;
  localparam int NMAG_W = 52;
  localparam int DMAG_W = 16;
  localparam int CNT_W  = 5;

  typedef logic signed [NORM_W-1:0]  normal_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAD_W-1:0]          radius_t;

  localparam logic [2:0] REG_NORMAL_X   = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y   = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z   = 3'd2;
  localparam logic [2:0] REG_SHIP_X     = 3'd3;
  localparam logic [2:0] REG_SHIP_Y     = 3'd4;
  localparam logic [2:0] REG_HIT_RADIUS = 3'd5;

  localparam normal_t NORMAL_X_RST   = 16'sd0;
  localparam normal_t NORMAL_Y_RST   = 16'sd0;
  localparam normal_t NORMAL_Z_RST   = 16'sd16384;
  localparam coord_t  SHIP_X_RST     = 32'sd0;
  localparam coord_t  SHIP_Y_RST     = 32'sd0;
  localparam radius_t HIT_RADIUS_RST = 31'd458752;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 65'sd8192;
  localparam int DOT_SHIFT  = 14;
  localparam int LO_SHIFT   = 16;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

endpackage

@@ rtl/projected_point_radius_hit_test.sv @@
// Each bullet transfer on the s_ side carries a point (x, y, z) in Q16.16. The point is projected
// onto the plane through the origin with the configured Q2.14 normal, its vertical plane
// coordinate is found by one signed division that truncates toward zero and saturates, and a hit
// is a squared distance to the ship strictly below the squared radius. Hits collect in a sticky
// flag that leaves as one m_ transfer on the bullet marked by s_tlast and is then cleared; other
// bullets give no transfer. A new bullet is taken only once the last one is finished, as s_tready
// is high only in the idle state. A full bullet goes through a 32-step restoring divider and
// eight passes through one shared 33 by 33 multiplier with its accumulator; a bullet that is
// ruled out early, such as one with a zero divisor, skips some of them and finishes sooner. A
// finished flag waits in the output register while the next bullet is taken in, and a last
// bullet holds in its final state while that register still holds a flag that has not been taken.
// Registers are written through the APB port at byte address 4 times their index.
module projected_point_radius_hit_test (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pprht_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pprht_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pprht_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0 up: bullet_x[31:0], bullet_y[63:32], bullet_z[95:64].
  input  logic [pprht_pkg::S_DATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0 up: collided[0], zero fill[7:1].
  output logic [pprht_pkg::M_DATA_W-1:0]      m_tdata
);
  import pprht_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M0   = 5'd1;
  localparam logic [4:0] S_M1   = 5'd2;
  localparam logic [4:0] S_M2   = 5'd3;
  localparam logic [4:0] S_M3   = 5'd4;
  localparam logic [4:0] S_RND  = 5'd5;
  localparam logic [4:0] S_P0   = 5'd6;
  localparam logic [4:0] S_P1   = 5'd7;
  localparam logic [4:0] S_P2   = 5'd8;
  localparam logic [4:0] S_DSET = 5'd9;
  localparam logic [4:0] S_DIV  = 5'd10;
  localparam logic [4:0] S_DEND = 5'd11;
  localparam logic [4:0] S_Q0   = 5'd12;
  localparam logic [4:0] S_Q1   = 5'd13;
  localparam logic [4:0] S_Q2   = 5'd14;
  localparam logic [4:0] S_Q3   = 5'd15;
  localparam logic [4:0] S_CMP  = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;

  normal_t normal_x, normal_y, normal_z;
  coord_t  ship_x, ship_y;
  radius_t hit_radius;

  logic [4:0] state;
  logic       hit_seen;
  logic       hit_now;
  logic       collided;
  logic       out_load;

  coord_t bullet_x, bullet_y, bullet_z;
  logic   last_bullet;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DOT_W-1:0]  dot16;
  logic signed [DOT_W-1:0]  dot_hi;

  logic signed [NORM_W:0] ny_ext, nz_ext;
  logic [NORM_W:0]        ny_abs, nz_abs;
  logic                   sel_y;
  normal_t                coef;
  logic [DMAG_W-1:0]      dmag;
  logic                   div_neg;

  logic                     num_neg;
  logic [ACC_W-1:0]         num_abs;
  logic [NMAG_W-COORD_W-1:0] num_hi;

  logic [DMAG_W-1:0]   rem;
  logic [COORD_W-1:0]  nlo;
  logic [CNT_W-1:0]    cnt;
  logic                quo_neg;
  logic                quo_sat;
  logic [DMAG_W+1:0]   trial;

  coord_t             by;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]   ux, uy;
  logic [RAD_W-1:0]   ux_q, uy_q;
  logic               out_range;
  logic               hit_total;
  logic               cfg_write;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x   <= NORMAL_X_RST;
      normal_y   <= NORMAL_Y_RST;
      normal_z   <= NORMAL_Z_RST;
      ship_x     <= SHIP_X_RST;
      ship_y     <= SHIP_Y_RST;
      hit_radius <= HIT_RADIUS_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_NORMAL_X:   normal_x   <= pwdata[NORM_W-1:0];
        REG_NORMAL_Y:   normal_y   <= pwdata[NORM_W-1:0];
        REG_NORMAL_Z:   normal_z   <= pwdata[NORM_W-1:0];
        REG_SHIP_X:     ship_x     <= pwdata[COORD_W-1:0];
        REG_SHIP_Y:     ship_y     <= pwdata[COORD_W-1:0];
        REG_HIT_RADIUS: hit_radius <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_NORMAL_X:   prdata = {16'd0, normal_x};
      REG_NORMAL_Y:   prdata = {16'd0, normal_y};
      REG_NORMAL_Z:   prdata = {16'd0, normal_z};
      REG_SHIP_X:     prdata = ship_x;
      REG_SHIP_Y:     prdata = ship_y;
      REG_HIT_RADIUS: prdata = {1'b0, hit_radius};
      default:        prdata = '0;
    endcase
  end

  // Divisor selection follows the larger normal magnitude.
  assign ny_ext  = (NORM_W+1)'(normal_y);
  assign nz_ext  = (NORM_W+1)'(normal_z);
  assign ny_abs  = ny_ext[NORM_W] ? (NORM_W+1)'(-ny_ext) : (NORM_W+1)'(ny_ext);
  assign nz_abs  = nz_ext[NORM_W] ? (NORM_W+1)'(-nz_ext) : (NORM_W+1)'(nz_ext);
  assign sel_y   = nz_abs > ny_abs;
  assign coef    = sel_y ? normal_y : normal_z;
  assign dmag    = sel_y ? nz_abs[DMAG_W-1:0] : ny_abs[DMAG_W-1:0];
  assign div_neg = sel_y ? !normal_z[NORM_W-1] : normal_y[NORM_W-1];

  assign dot_hi = dot16 >>> LO_SHIFT;

  always_comb begin
    unique case (state)
      S_M0: begin
        mul_a = MUL_W'(normal_x);
        mul_b = MUL_W'(bullet_x);
      end
      S_M1: begin
        mul_a = MUL_W'(normal_y);
        mul_b = MUL_W'(bullet_y);
      end
      S_M2: begin
        mul_a = MUL_W'(normal_z);
        mul_b = MUL_W'(bullet_z);
      end
      S_P0: begin
        mul_a = MUL_W'(coef);
        mul_b = MUL_W'(dot_hi);
      end
      S_P1: begin
        mul_a = MUL_W'(coef);
        mul_b = {17'd0, dot16[LO_SHIFT-1:0]};
      end
      S_Q0: begin
        mul_a = {2'b00, ux_q};
        mul_b = {2'b00, ux_q};
      end
      S_Q1: begin
        mul_a = {2'b00, uy_q};
        mul_b = {2'b00, uy_q};
      end
      S_Q2: begin
        mul_a = {2'b00, hit_radius};
        mul_b = {2'b00, hit_radius};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign num_neg = acc[ACC_W-1];
  assign num_abs = num_neg ? ACC_W'(-acc) : ACC_W'(acc);
  assign num_hi  = num_abs[NMAG_W-1:COORD_W];

  assign trial = {1'b0, rem, nlo[COORD_W-1]} - {2'b00, dmag};

  always_comb begin
    if (quo_sat || nlo[COORD_W-1]) begin
      by = quo_neg ? COORD_MIN : COORD_MAX;
    end else if (quo_neg) begin
      by = COORD_W'(-nlo);
    end else begin
      by = nlo;
    end
  end

  assign dx        = (COORD_W+1)'(bullet_x) - (COORD_W+1)'(ship_x);
  assign dy        = (COORD_W+1)'(by) - (COORD_W+1)'(ship_y);
  assign ux        = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
  assign uy        = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
  assign out_range = (ux >= {2'b00, hit_radius}) || (uy >= {2'b00, hit_radius});
  assign hit_total = hit_seen | hit_now;
  assign out_load  = (state == S_FIN) && last_bullet && (!m_tvalid || m_tready);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'd0, collided};

  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hit_seen <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            bullet_x    <= s_tdata[31:0];
            bullet_y    <= s_tdata[63:32];
            bullet_z    <= s_tdata[95:64];
            last_bullet <= s_tlast;
            state       <= S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          acc   <= ACC_W'(prod);
          state <= S_M2;
        end
        S_M2: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_M3;
        end
        S_M3: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_RND;
        end
        S_RND: begin
          dot16 <= DOT_W'((acc + ROUND_HALF) >>> DOT_SHIFT);
          acc   <= ACC_W'(sel_y ? bullet_y : bullet_z) <<< DOT_SHIFT;
          state <= S_P0;
        end
        S_P0: state <= S_P1;
        S_P1: begin
          acc   <= acc - (ACC_W'(prod) <<< LO_SHIFT);
          state <= S_P2;
        end
        S_P2: begin
          acc   <= acc - ACC_W'(prod);
          state <= S_DSET;
        end
        S_DSET: begin
          quo_neg <= num_neg ^ div_neg;
          rem     <= num_hi[DMAG_W-1:0];
          nlo     <= num_abs[COORD_W-1:0];
          cnt     <= '0;
          if (dmag == '0) begin
            quo_sat <= 1'b0;
            hit_now <= 1'b0;
            state   <= S_FIN;
          end else if (num_hi >= (NMAG_W-COORD_W)'(dmag)) begin
            quo_sat <= 1'b1;
            state   <= S_DEND;
          end else begin
            quo_sat <= 1'b0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[DMAG_W+1]) begin
            rem <= trial[DMAG_W-1:0];
            nlo <= {nlo[COORD_W-2:0], 1'b1};
          end else begin
            rem <= {rem[DMAG_W-2:0], nlo[COORD_W-1]};
            nlo <= {nlo[COORD_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_DEND;
          end
        end
        S_DEND: begin
          ux_q <= ux[RAD_W-1:0];
          uy_q <= uy[RAD_W-1:0];
          if (out_range) begin
            hit_now <= 1'b0;
            state   <= S_FIN;
          end else begin
            state <= S_Q0;
          end
        end
        S_Q0: state <= S_Q1;
        S_Q1: begin
          acc   <= ACC_W'(prod);
          state <= S_Q2;
        end
        S_Q2: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_Q3;
        end
        S_Q3: begin
          acc   <= acc - ACC_W'(prod);
          state <= S_CMP;
        end
        S_CMP: begin
          hit_now <= acc[ACC_W-1];
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!last_bullet) begin
            hit_seen <= hit_total;
            state    <= S_IDLE;
          end else if (out_load) begin
            collided <= hit_total;
            hit_seen <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
